[hw/rtl/ue_session_table_engine_assert.svh]
// Assertion macros shared by the session table engine RTL.
`ifndef UE_SESSION_TABLE_ENGINE_ASSERT_SVH
`define UE_SESSION_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define UE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("session table assertion failed");
`define UE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("session table assertion failed");
`else
`define UE_ASSERT_IMP(lbl, ante, cons)
`define UE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/ue_ste_pkg.sv]
// Types and constants of the session table engine.
package ue_ste_pkg;
  localparam int SESSION_SLOTS = 16;
  localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int CNT_W  = $clog2(SESSION_SLOTS + 1);

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]  slot_cnt_t;
  typedef logic [0:0]        cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_TIMEOUT   = 1'b0;
  localparam cfg_idx_t REG_FIRST_SID = 1'b1;

  // Command codes.
  localparam logic [2:0] CMD_ATTACH = 3'd0;
  localparam logic [2:0] CMD_DETACH = 3'd1;
  localparam logic [2:0] CMD_HBEAT  = 3'd2;
  localparam logic [2:0] CMD_DATA   = 3'd3;
  localparam logic [2:0] CMD_SWEEP  = 3'd4;

  // Reply codes.
  localparam logic [1:0] RPL_ATTACH = 2'd0;
  localparam logic [1:0] RPL_DETACH = 2'd1;
  localparam logic [1:0] RPL_HBEAT  = 2'd2;
  localparam logic [1:0] RPL_ERROR  = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;
endpackage

[hw/rtl/ue_session_table_engine.sv]
// Session table engine: slot table, walking sequencer and reply register.
//
// Usage: commands arrive as beats on the in_ channel (valid/ready); each
// command yields exactly one result beat on the out_ channel, whose
// out_reply_valid tells whether it carries a reply message. The cfg_ port
// writes the idle timeout (index 0) and the first session id (index 1); the
// latter also reloads the session id allocator.
// Attach, detach, heartbeat and data walk every slot once with a single
// device-id comparator, decide and update the hit or free slot in the
// execute state, and then move the result into the output register in
// the done state. An expire sweep walks every slot with one shared
// subtract-and-compare unit and then passes to the done state; unused
// command codes go straight to the done state.
// Throughput: one command at a time; in_ready is high only while idle.
// Reset clears all slot valid bits, the counters and the output beat, and
// restores the timeout to 30000 and the next session id to 1.
// When the receiver stalls, a waiting result beat holds; the engine may take
// one more command and finish it, then waits until the output is free.
module ue_session_table_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_command,
  input  logic [31:0]          in_ue_id,
  input  logic [31:0]          in_session_id,
  input  logic [31:0]          in_sequence_number,
  input  logic [15:0]          in_declared_length,
  input  logic [15:0]          in_payload_size,
  input  logic [47:0]          in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_reply_valid,
  output logic [1:0]           out_reply_type,
  output logic [31:0]          out_reply_ue_id,
  output logic [31:0]          out_reply_session_id,
  output logic [31:0]          out_reply_sequence,
  output logic [47:0]          out_reply_timestamp,
  output logic [4:0]           out_active_sessions,
  output logic [47:0]          out_delivered_bytes_total,
  output logic [47:0]          out_delivered_packets_total,
  output logic [31:0]          out_expired_total,
  input  logic                 cfg_we,
  input  ue_ste_pkg::cfg_idx_t cfg_index,
  input  logic [47:0]          cfg_wdata
);
  import ue_ste_pkg::*;

  localparam slot_idx_t LAST_IDX = SLOT_W'(SESSION_SLOTS - 1);

  // Slot table.
  logic [SESSION_SLOTS-1:0] slot_vld_r;
  logic [31:0] slot_dev_r  [SESSION_SLOTS];
  logic [31:0] slot_sess_r [SESSION_SLOTS];
  logic [31:0] slot_seq_r  [SESSION_SLOTS];
  logic [47:0] slot_seen_r [SESSION_SLOTS];

  // Control and counters.
  state_t      st_r;
  slot_idx_t   idx_r, hit_idx_r, free_idx_r;
  logic        hit_found_r, free_found_r;
  slot_cnt_t   act_r;
  logic [47:0] tmo_r;
  logic [31:0] next_sid_r;
  logic [47:0] bytes_r, pkts_r;
  logic [31:0] expired_r;
  logic        out_valid_r;

  // Latched command.
  logic [2:0]  cmd_r;
  logic [31:0] cmd_dev_r, cmd_sid_r, cmd_seq_r;
  logic [15:0] cmd_dlen_r, cmd_psz_r;
  logic [47:0] cmd_now_r;

  // Pending result.
  logic        res_rv_r;
  logic [1:0]  res_type_r;
  logic [31:0] res_dev_r, res_sid_r, res_seq_r;
  logic [47:0] res_now_r;

  // Output register.
  logic        o_rv_r;
  logic [1:0]  o_type_r;
  logic [31:0] o_dev_r, o_sid_r, o_seq_r;
  logic [47:0] o_now_r;
  logic [4:0]  o_act_r;
  logic [47:0] o_bytes_r, o_pkts_r;
  logic [31:0] o_exp_r;

  logic in_fire, out_load;
  assign in_ready = (st_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (st_r == ST_DONE) && (!out_valid_r || out_ready);

  // Shared comparator of the slot walk.
  logic scan_match, scan_free;
  assign scan_match = slot_vld_r[idx_r] && (slot_dev_r[idx_r] == cmd_dev_r);
  assign scan_free  = !slot_vld_r[idx_r];

  // Shared subtract-and-compare unit of the expire sweep.
  logic [47:0] sw_idle;
  logic        sw_kill;
  assign sw_idle = cmd_now_r - slot_seen_r[idx_r];
  assign sw_kill = (st_r == ST_SWEEP) && slot_vld_r[idx_r] && (sw_idle >= tmo_r);

  // Decision for the command once the walk has found its slots.
  logic [31:0] hit_sess, hit_seq;
  logic        sess_ok, seq_newer, len_ok;
  logic        d_rv, d_new, d_seen, d_seq, d_clr, d_data;
  logic [1:0]  d_type;
  logic [31:0] d_sid;

  assign hit_sess  = slot_sess_r[hit_idx_r];
  assign hit_seq   = slot_seq_r[hit_idx_r];
  assign sess_ok   = hit_found_r && (hit_sess == cmd_sid_r);
  assign seq_newer = cmd_seq_r > hit_seq;
  assign len_ok    = (cmd_psz_r == cmd_dlen_r) && (cmd_psz_r != 16'd0);

  always_comb begin
    d_rv   = 1'b0;
    d_type = RPL_ATTACH;
    d_sid  = cmd_sid_r;
    d_new  = 1'b0;
    d_seen = 1'b0;
    d_seq  = 1'b0;
    d_clr  = 1'b0;
    d_data = 1'b0;
    unique case (cmd_r)
      CMD_ATTACH: begin
        d_rv = 1'b1;
        if (cmd_dev_r == 32'd0 || cmd_seq_r == 32'd0 || cmd_sid_r != 32'd0) begin
          d_type = RPL_ERROR;
        end else if (hit_found_r) begin
          d_seen = 1'b1;
          d_sid  = hit_sess;
        end else if (free_found_r) begin
          d_new = 1'b1;
          d_sid = next_sid_r;
        end else begin
          d_type = RPL_ERROR;
        end
      end
      CMD_DETACH: begin
        if (!hit_found_r) begin
          d_rv   = 1'b1;
          d_type = RPL_DETACH;
        end else if (!sess_ok) begin
          d_rv   = 1'b1;
          d_type = RPL_ERROR;
        end else if (seq_newer) begin
          d_rv   = 1'b1;
          d_type = RPL_DETACH;
          d_clr  = 1'b1;
        end
      end
      CMD_HBEAT: begin
        if (sess_ok && seq_newer) begin
          d_rv   = 1'b1;
          d_type = RPL_HBEAT;
          d_sid  = hit_sess;
          d_seen = 1'b1;
          d_seq  = 1'b1;
        end
      end
      CMD_DATA: begin
        if (sess_ok && seq_newer && len_ok) begin
          d_seen = 1'b1;
          d_seq  = 1'b1;
          d_data = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  logic do_exec;
  assign do_exec = (st_r == ST_EXEC);

  // Slot payload storage.
  always_ff @(posedge clk) begin
    if (do_exec && d_new) begin
      slot_dev_r[free_idx_r]  <= cmd_dev_r;
      slot_sess_r[free_idx_r] <= next_sid_r;
      slot_seq_r[free_idx_r]  <= cmd_seq_r;
      slot_seen_r[free_idx_r] <= cmd_now_r;
    end
    if (do_exec && d_seen) begin
      slot_seen_r[hit_idx_r] <= cmd_now_r;
    end
    if (do_exec && d_seq) begin
      slot_seq_r[hit_idx_r] <= cmd_seq_r;
    end
  end

  // Command, result and output payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= in_command;
      cmd_dev_r  <= in_ue_id;
      cmd_sid_r  <= in_session_id;
      cmd_seq_r  <= in_sequence_number;
      cmd_dlen_r <= in_declared_length;
      cmd_psz_r  <= in_payload_size;
      cmd_now_r  <= in_now_ms;
      res_rv_r   <= 1'b0;
      res_type_r <= 2'd0;
      res_dev_r  <= 32'd0;
      res_sid_r  <= 32'd0;
      res_seq_r  <= 32'd0;
      res_now_r  <= 48'd0;
    end
    if (do_exec) begin
      res_rv_r   <= d_rv;
      res_type_r <= d_rv ? d_type : 2'd0;
      res_dev_r  <= d_rv ? cmd_dev_r : 32'd0;
      res_sid_r  <= d_rv ? d_sid : 32'd0;
      res_seq_r  <= d_rv ? cmd_seq_r : 32'd0;
      res_now_r  <= d_rv ? cmd_now_r : 48'd0;
    end
    if (out_load) begin
      o_rv_r    <= res_rv_r;
      o_type_r  <= res_type_r;
      o_dev_r   <= res_dev_r;
      o_sid_r   <= res_sid_r;
      o_seq_r   <= res_seq_r;
      o_now_r   <= res_now_r;
      o_act_r   <= 5'(act_r);
      o_bytes_r <= bytes_r;
      o_pkts_r  <= pkts_r;
      o_exp_r   <= expired_r;
    end
  end

  // Sequencer, valid bits, counters and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      idx_r        <= '0;
      hit_idx_r    <= '0;
      free_idx_r   <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      slot_vld_r   <= '0;
      act_r        <= '0;
      tmo_r        <= 48'd30000;
      next_sid_r   <= 32'd1;
      bytes_r      <= '0;
      pkts_r       <= '0;
      expired_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIMEOUT:   tmo_r <= cfg_wdata;
          REG_FIRST_SID: next_sid_r <= cfg_wdata[31:0];
          default: begin
          end
        endcase
      end

      // The beat leaves unless a new one replaces it at this edge.
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            idx_r        <= '0;
            hit_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            if (in_command == CMD_SWEEP) begin
              st_r <= ST_SWEEP;
            end else if (in_command == CMD_ATTACH || in_command == CMD_DETACH ||
                         in_command == CMD_HBEAT || in_command == CMD_DATA) begin
              st_r <= ST_SCAN;
            end else begin
              st_r <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // Lowest matching slot and lowest free slot.
          if (scan_match && !hit_found_r) begin
            hit_found_r <= 1'b1;
            hit_idx_r   <= idx_r;
          end
          if (scan_free && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= idx_r;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            st_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (d_new) begin
            slot_vld_r[free_idx_r] <= 1'b1;
            act_r      <= act_r + 1'b1;
            next_sid_r <= next_sid_r + 32'd1;
          end
          if (d_clr) begin
            slot_vld_r[hit_idx_r] <= 1'b0;
            act_r <= act_r - 1'b1;
          end
          if (d_data) begin
            bytes_r <= bytes_r + 48'(cmd_psz_r);
            pkts_r  <= pkts_r + 48'd1;
          end
          st_r <= ST_DONE;
        end
        ST_SWEEP: begin
          if (sw_kill) begin
            slot_vld_r[idx_r] <= 1'b0;
            act_r     <= act_r - 1'b1;
            expired_r <= expired_r + 32'd1;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_reply_valid             = o_rv_r;
  assign out_reply_type              = o_type_r;
  assign out_reply_ue_id             = o_dev_r;
  assign out_reply_session_id        = o_sid_r;
  assign out_reply_sequence          = o_seq_r;
  assign out_reply_timestamp         = o_now_r;
  assign out_active_sessions         = o_act_r;
  assign out_delivered_bytes_total   = o_bytes_r;
  assign out_delivered_packets_total = o_pkts_r;
  assign out_expired_total           = o_exp_r;

`include "ue_session_table_engine_assert.svh"

  // The occupancy count tracks the valid bits.
  `UE_ASSERT_IMP(a_act_count, 1'b1, act_r == CNT_W'($countones(slot_vld_r)))
  // A hit found by the walk points at an occupied slot.
  `UE_ASSERT_IMP(a_hit_valid, do_exec && hit_found_r, slot_vld_r[hit_idx_r])
  // An accepted command leaves the idle state.
  `UE_ASSERT_NXT(a_busy_after_accept, in_fire, st_r != ST_IDLE)
  // A finished result waits while the output beat is stalled.
  `UE_ASSERT_NXT(a_done_waits, (st_r == ST_DONE) && out_valid_r && !out_ready,
                 st_r == ST_DONE)
endmodule
